FILE: src/framed_packet_header_crc_checker_top_macros.svh
// ----------------------------------------------------------------------------
// Framed packet header CRC checker assertion macros
// Shared property wrappers for the checker's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_HEADER_CRC_CHECKER_TOP_MACROS_SVH
`define FRAMED_PACKET_HEADER_CRC_CHECKER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPHCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPHCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fphcc_pkg.sv
// ----------------------------------------------------------------------------
// Framed packet header CRC checker package
// Constants, status codes, register indexes, the frame view type and the
// CRC-16 byte update shared by the checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fphcc_pkg;

    localparam int HEADER_BYTES_DEF = 12;
    localparam int KEPT_HEADER      = 10;
    localparam int HDR_IDX_W        = $clog2(KEPT_HEADER);

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_TOP   = 16'h8000;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_TRUNC   = 3'd1;
    localparam t_status ST_MAGIC   = 3'd2;
    localparam t_status ST_VERSION = 3'd3;
    localparam t_status ST_CRC     = 3'd4;

    typedef enum logic {
        CFG_MAGIC   = 1'b0,
        CFG_VERSION = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [15:0]                  count;
        logic [15:0]                  crc;
        logic [KEPT_HEADER-1:0][7:0]  hdr;
    } t_frame_view;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/fphcc_frame.sv
// ----------------------------------------------------------------------------
// Framed packet header CRC checker frame state
// Holds the byte count, the running body CRC and the kept header bytes, and
// presents their values updated by the byte in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module fphcc_frame
    import fphcc_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    output t_frame_view      o_view,
    output logic [15:0]      o_count
);

    logic [15:0]                 r_count;
    logic [15:0]                 r_crc;
    logic [KEPT_HEADER-1:0][7:0] r_hdr;
    logic [15:0]                 w_blen;
    logic                        w_in_body;
    t_frame_view                 n_view;

    assign w_blen    = {r_hdr[7], r_hdr[6]};
    assign w_in_body = (r_count >= 16'(HEADER_BYTES))
                     && ((r_count - 16'(HEADER_BYTES)) < w_blen);

    always_comb begin
        n_view.count = r_count;
        n_view.crc   = r_crc;
        n_view.hdr   = r_hdr;
        if (r_count != COUNT_MAX) begin
            if (r_count < 16'(KEPT_HEADER)) begin
                n_view.hdr[r_count[HDR_IDX_W-1:0]] = i_byte;
            end
            if (w_in_body) begin
                n_view.crc = crc_byte(r_crc, i_byte);
            end
            n_view.count = r_count + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 16'd0;
            r_crc   <= CRC_INIT;
        end else if (i_adv) begin
            if (i_last) begin
                r_count <= 16'd0;
                r_crc   <= CRC_INIT;
            end else begin
                r_count <= n_view.count;
                r_crc   <= n_view.crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_hdr <= n_view.hdr;
        end
    end

    assign o_view  = n_view;
    assign o_count = r_count;

endmodule

`default_nettype wire

FILE: src/fphcc_result.sv
// ----------------------------------------------------------------------------
// Framed packet header CRC checker result stage
// Judges a finished frame and holds the verdict with the parsed header
// fields in the output register until the transaction completes.
// ----------------------------------------------------------------------------
`default_nettype none

module fphcc_result
    import fphcc_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_load,
    input  wire t_frame_view i_view,
    input  wire logic [15:0] i_magic,
    input  wire logic [7:0]  i_version,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [2:0]       o_status,
    output logic [7:0]       o_num_blocks,
    output logic [7:0]       o_num_edges,
    output logic [7:0]       o_header_flags,
    output logic [15:0]      o_payload_len,
    output logic [15:0]      o_stated_crc
);

    logic        r_valid;
    t_status     r_status;
    logic [7:0]  r_num_blocks;
    logic [7:0]  r_num_edges;
    logic [7:0]  r_header_flags;
    logic [15:0] r_payload_len;
    logic [15:0] r_stated_crc;

    logic        w_hdr_short;
    logic        w_body_short;
    logic [15:0] w_blen;
    logic [15:0] w_stated;
    t_status     n_status;

    assign w_blen       = {i_view.hdr[7], i_view.hdr[6]};
    assign w_stated     = {i_view.hdr[9], i_view.hdr[8]};
    assign w_hdr_short  = i_view.count < 16'(HEADER_BYTES);
    assign w_body_short = (17'(HEADER_BYTES) + {1'b0, w_blen}) > {1'b0, i_view.count};

    always_comb begin
        if (w_hdr_short) begin
            n_status = ST_TRUNC;
        end else if ({i_view.hdr[1], i_view.hdr[0]} != i_magic) begin
            n_status = ST_MAGIC;
        end else if (i_view.hdr[2] != i_version) begin
            n_status = ST_VERSION;
        end else if (w_body_short) begin
            n_status = ST_TRUNC;
        end else if (i_view.crc != w_stated) begin
            n_status = ST_CRC;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= n_status;
            if (w_hdr_short) begin
                r_num_blocks   <= 8'd0;
                r_num_edges    <= 8'd0;
                r_header_flags <= 8'd0;
                r_payload_len  <= 16'd0;
                r_stated_crc   <= 16'd0;
            end else begin
                r_num_blocks   <= i_view.hdr[3];
                r_num_edges    <= i_view.hdr[4];
                r_header_flags <= i_view.hdr[5];
                r_payload_len  <= w_blen;
                r_stated_crc   <= w_stated;
            end
        end
    end

    assign o_out_valid    = r_valid;
    assign o_status       = r_status;
    assign o_num_blocks   = r_num_blocks;
    assign o_num_edges    = r_num_edges;
    assign o_header_flags = r_header_flags;
    assign o_payload_len  = r_payload_len;
    assign o_stated_crc   = r_stated_crc;

endmodule

`default_nettype wire

FILE: src/framed_packet_header_crc_checker_top.sv
// ----------------------------------------------------------------------------
// Framed packet header CRC checker
// Takes a frame one byte per transaction, with last_byte set on its final
// byte, and checks the little-endian header against the configured magic and
// version and the body against a CRC-16 (polynomial 0x1021, init 0xFFFF).
// One byte is accepted every cycle while no last byte waits. A byte is captured
// in the input register and judged from there by the CRC byte update and the
// header compares into the output register; the CRC byte update is the longest
// path. A frame's last byte waits in the input register only while an earlier
// verdict is still held by the output. Write configuration registers only while
// no frame is in progress.
// ----------------------------------------------------------------------------
`default_nettype none
`include "framed_packet_header_crc_checker_top_macros.svh"

module framed_packet_header_crc_checker_top
    import fphcc_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [7:0]       o_num_blocks,
    output logic [7:0]       o_num_edges,
    output logic [7:0]       o_header_flags,
    output logic [15:0]      o_payload_len,
    output logic [15:0]      o_stated_crc
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [15:0] r_magic;
    logic [7:0]  r_version;

    logic        w_out_free;
    logic        w_adv;
    t_frame_view w_view;
    logic [15:0] w_frame_count;

    assign w_out_free = !o_out_valid || i_out_ready;
    assign w_adv      = r_in_valid && (!r_in_last || w_out_free);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_byte_value;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= 16'd0;
            r_version <= 8'd0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MAGIC: begin
                    r_magic <= i_cfg_data;
                end
                CFG_VERSION: begin
                    r_version <= i_cfg_data[7:0];
                end
                default: begin
                    r_magic <= r_magic;
                end
            endcase
        end
    end

    fphcc_frame #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_view  (w_view),
        .o_count (w_frame_count)
    );

    fphcc_result #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_adv && r_in_last),
        .i_view         (w_view),
        .i_magic        (r_magic),
        .i_version      (r_version),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_num_blocks   (o_num_blocks),
        .o_num_edges    (o_num_edges),
        .o_header_flags (o_header_flags),
        .o_payload_len  (o_payload_len),
        .o_stated_crc   (o_stated_crc)
    );

    `FPHCC_ASSERT_NOW(a_status_range, i_clk, i_rst_n, o_out_valid, o_status <= ST_CRC,
        "status code out of range")
    `FPHCC_ASSERT_NOW(a_last_waits, i_clk, i_rst_n,
        r_in_valid && r_in_last && o_out_valid && !i_out_ready, !o_in_ready,
        "last byte overran a held verdict")
    `FPHCC_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, w_adv && r_in_last,
        w_frame_count == 16'd0, "frame count not cleared after last byte")

endmodule

`default_nettype wire

FILE: verif/framed_packet_header_crc_checker_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framed packet header CRC checker testbench
// Sends frames one byte per transaction and predicts each verdict with a
// CRC-16 and header model of its own. Covers reset settings, every verdict
// and random frames under several register settings, with random gaps on
// the byte side and random stalls on the verdict side.
// ----------------------------------------------------------------------------

module framed_packet_header_crc_checker_top_test;
    import fphcc_pkg::*;

    localparam int HDR_LEN       = HEADER_BYTES_DEF;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        t_status     status;
        logic [7:0]  blocks;
        logic [7:0]  edges;
        logic [7:0]  flags;
        logic [15:0] blen;
        logic [15:0] scrc;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_byte_value;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic [7:0]  o_num_blocks;
    logic [7:0]  o_num_edges;
    logic [7:0]  o_header_flags;
    logic [15:0] o_payload_len;
    logic [15:0] o_stated_crc;

    logic [15:0] cfg_magic;
    logic [7:0]  cfg_version;
    int          fr_count;
    logic [15:0] fr_crc;
    logic [7:0]  fr_hdr [KEPT_HEADER];
    t_verdict    verdict_q [$];
    logic [7:0]  frame_buf [$];
    int          err_count;

    framed_packet_header_crc_checker_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_byte_value   (i_byte_value),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_num_blocks   (o_num_blocks),
        .o_num_edges    (o_num_edges),
        .o_header_flags (o_header_flags),
        .o_payload_len  (o_payload_len),
        .o_stated_crc   (o_stated_crc)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic void clear_frame();
        fr_count = 0;
        fr_crc   = CRC_INIT;
        for (int i = 0; i < KEPT_HEADER; i++) begin
            fr_hdr[i] = 8'h00;
        end
    endfunction

    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        t_verdict    v;
        logic [15:0] blen;
        blen = {fr_hdr[7], fr_hdr[6]};
        if (fr_count < 65535) begin
            if (fr_count < KEPT_HEADER) begin
                fr_hdr[fr_count] = b;
            end
            if (fr_count >= HDR_LEN && fr_count - HDR_LEN < int'(blen)) begin
                fr_crc = crc_step(fr_crc, b);
            end
            fr_count++;
        end
        if (last) begin
            blen = {fr_hdr[7], fr_hdr[6]};
            if (fr_count < HDR_LEN) begin
                v.status = ST_TRUNC;
            end else if ({fr_hdr[1], fr_hdr[0]} != cfg_magic) begin
                v.status = ST_MAGIC;
            end else if (fr_hdr[2] != cfg_version) begin
                v.status = ST_VERSION;
            end else if (HDR_LEN + int'(blen) > fr_count) begin
                v.status = ST_TRUNC;
            end else if (fr_crc != {fr_hdr[9], fr_hdr[8]}) begin
                v.status = ST_CRC;
            end else begin
                v.status = ST_OK;
            end
            if (fr_count < HDR_LEN) begin
                v.blocks = 8'h00;
                v.edges  = 8'h00;
                v.flags  = 8'h00;
                v.blen   = 16'h0000;
                v.scrc   = 16'h0000;
            end else begin
                v.blocks = fr_hdr[3];
                v.edges  = fr_hdr[4];
                v.flags  = fr_hdr[5];
                v.blen   = blen;
                v.scrc   = {fr_hdr[9], fr_hdr[8]};
            end
            verdict_q.push_back(v);
            clear_frame();
        end
    endfunction

    function automatic int pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("ERROR: %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    always @(posedge i_clk) begin : check_verdicts
        t_verdict want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("verdict with none pending", 16'(o_status), 16'h0000);
            end else begin
                want = verdict_q.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch("status", 16'(o_status), 16'(want.status));
                end
                if (o_num_blocks !== want.blocks) begin
                    report_mismatch("num_blocks", 16'(o_num_blocks), 16'(want.blocks));
                end
                if (o_num_edges !== want.edges) begin
                    report_mismatch("num_edges", 16'(o_num_edges), 16'(want.edges));
                end
                if (o_header_flags !== want.flags) begin
                    report_mismatch("header_flags", 16'(o_header_flags), 16'(want.flags));
                end
                if (o_payload_len !== want.blen) begin
                    report_mismatch("payload_len", o_payload_len, want.blen);
                end
                if (o_stated_crc !== want.scrc) begin
                    report_mismatch("stated_crc", o_stated_crc, want.scrc);
                end
            end
        end
    end

    initial begin : verdict_sink
        int run;
        i_out_ready = 1'b0;
        forever begin
            run = $urandom_range(1, 20);
            repeat (run) @(negedge i_clk) i_out_ready <= 1'b1;
            run = ($urandom_range(0, 9) < 3) ? 0 : pick_delay();
            repeat (run) @(negedge i_clk) i_out_ready <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_byte_value <= b;
        i_last_byte  <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        absorb_byte(b, last);
    endtask

    task automatic send_frame(input logic gappy);
        for (int k = 0; k < frame_buf.size(); k++) begin
            send_byte(frame_buf[k], k == frame_buf.size() - 1, gappy ? pick_delay() : 0);
        end
    endtask

    task automatic drain_verdicts();
        int waited;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        waited = 0;
        while (verdict_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_MAGIC) begin
            cfg_magic = val;
        end else begin
            cfg_version = val[7:0];
        end
    endtask

    task automatic set_config(input logic [15:0] magic, input logic [7:0] version);
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_VERSION, {8'h00, version});
    endtask

    // The stated CRC covers the first blen body bytes, then crc_flip is applied to it.
    task automatic build_frame(input logic [15:0] magic, input logic [7:0] version,
                               input int blen, input int body_n, input logic [15:0] crc_flip);
        logic [7:0]  body [$];
        logic [15:0] crc;
        logic [15:0] len16;
        logic [7:0]  b;
        crc   = CRC_INIT;
        len16 = 16'(blen);
        for (int k = 0; k < body_n; k++) begin
            b = 8'($urandom);
            body.push_back(b);
            if (k < blen) begin
                crc = crc_step(crc, b);
            end
        end
        crc = crc ^ crc_flip;
        frame_buf.delete();
        frame_buf.push_back(magic[7:0]);
        frame_buf.push_back(magic[15:8]);
        frame_buf.push_back(version);
        for (int k = 0; k < 3; k++) begin
            b = 8'($urandom);
            frame_buf.push_back(b);
        end
        frame_buf.push_back(len16[7:0]);
        frame_buf.push_back(len16[15:8]);
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
        for (int k = 10; k < HDR_LEN; k++) begin
            b = 8'($urandom);
            frame_buf.push_back(b);
        end
        foreach (body[k]) begin
            frame_buf.push_back(body[k]);
        end
    endtask

    task automatic fill_random(input int n);
        logic [7:0] b;
        frame_buf.delete();
        for (int k = 0; k < n; k++) begin
            b = 8'($urandom);
            frame_buf.push_back(b);
        end
    endtask

    task automatic test_reset_values();
        build_frame(16'h0000, 8'h00, 0, 0, 16'h0000);
        send_frame(1'b0);
        build_frame(16'h0000, 8'h00, 2, 2, 16'h0000);
        send_frame(1'b1);
        drain_verdicts();
    endtask

    task automatic test_header_checks();
        frame_buf = {8'h00};
        send_frame(1'b0);
        frame_buf.delete();
        for (int k = 0; k < HDR_LEN - 1; k++) begin
            frame_buf.push_back(8'hFF);
        end
        send_frame(1'b0);
        build_frame(cfg_magic, cfg_version, 0, 0, 16'h0000);
        send_frame(1'b0);
        build_frame(cfg_magic, cfg_version, 3, 3, 16'h0000);
        send_frame(1'b1);
        build_frame(cfg_magic, cfg_version, 2, 5, 16'h0000);
        send_frame(1'b0);
        build_frame(cfg_magic ^ 16'h0001, cfg_version ^ 8'h01, 2, 2, 16'h0000);
        send_frame(1'b1);
        build_frame(cfg_magic, cfg_version ^ 8'h80, 2, 2, 16'h0000);
        send_frame(1'b0);
        build_frame(cfg_magic, cfg_version, 4, 0, 16'h0000);
        send_frame(1'b0);
        build_frame(cfg_magic, cfg_version, 65535, 3, 16'h0000);
        send_frame(1'b1);
        build_frame(cfg_magic, cfg_version, 3, 3, 16'h8000);
        send_frame(1'b0);
        drain_verdicts();
    endtask

    task automatic run_random_phase(input int byte_goal, input int frame_goal);
        int   sent_bytes;
        int   frames;
        int   kind;
        int   blen;
        int   body_n;
        logic gappy;
        logic [15:0] bad_magic;
        logic [7:0]  any_version;
        sent_bytes = 0;
        frames     = 0;
        while (sent_bytes < byte_goal || frames < frame_goal) begin
            kind  = $urandom_range(0, 99);
            blen  = $urandom_range(0, 12);
            gappy = ($urandom_range(0, 3) != 0);
            if (kind < 60) begin
                body_n = blen + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
                build_frame(cfg_magic, cfg_version, blen, body_n, 16'h0000);
            end else if (kind < 68) begin
                build_frame(cfg_magic, cfg_version, blen, blen,
                            16'h0001 << $urandom_range(0, 15));
            end else if (kind < 75) begin
                bad_magic   = cfg_magic ^ (16'h0001 << $urandom_range(0, 15));
                any_version = 8'($urandom);
                build_frame(bad_magic, any_version, blen, blen, 16'h0000);
            end else if (kind < 81) begin
                build_frame(cfg_magic, cfg_version ^ (8'h01 << $urandom_range(0, 7)),
                            blen, blen, 16'h0000);
            end else if (kind < 88) begin
                blen   = $urandom_range(0, 1) ? $urandom_range(1, 65535) : $urandom_range(1, 12);
                body_n = $urandom_range(0, (blen > 12) ? 11 : blen - 1);
                build_frame(cfg_magic, cfg_version, blen, body_n, 16'h0000);
            end else if (kind < 94) begin
                fill_random($urandom_range(1, HDR_LEN - 1));
            end else begin
                fill_random($urandom_range(1, 30));
            end
            send_frame(gappy);
            sent_bytes += frame_buf.size();
            frames++;
        end
        drain_verdicts();
    endtask

    task automatic test_random_frames();
        logic [15:0] m;
        logic [7:0]  v;
        set_config(16'h0000, 8'hFF);
        run_random_phase(90, 6);
        m = 16'($urandom);
        v = 8'($urandom);
        set_config(m, v);
        run_random_phase(90, 6);
        set_config(16'hFFFF, 8'h00);
        run_random_phase(90, 6);
        m = 16'($urandom);
        v = 8'($urandom);
        set_config(m, v);
        run_random_phase(90, 6);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_MAGIC;
        i_cfg_data   = 16'h0000;
        i_in_valid   = 1'b0;
        i_byte_value = 8'h00;
        i_last_byte  = 1'b0;
        err_count    = 0;
        cfg_magic    = 16'h0000;
        cfg_version  = 8'h00;
        clear_frame();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        set_config(16'hFFFF, 8'hFF);
        test_header_checks();
        test_random_frames();

        if (verdict_q.size() != 0) begin
            report_mismatch("verdicts never delivered", 16'(verdict_q.size()), 16'h0000);
        end
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
